>>> design/pwg_pkg.sv
// ----------------------------------------------------------------------------
// pwg_pkg: shared types and constants of the periodic waveform generator
// holds register indexes, wave codes, the ecg table and controller commands
// ----------------------------------------------------------------------------
`default_nettype none
package pwg_pkg;

	localparam int ECG_LEN    = 253;
	localparam int SINE_STEPS = 1024;
	localparam int MAX_SMOOTH = 16;
	localparam int TIME_BITS  = 32;
	localparam int PER_W      = 15;
	localparam int AMP_W      = 15;
	localparam int LVL_W      = 15;

	// register indexes
	localparam logic [2:0] REG_PERIOD   = 3'd0;
	localparam logic [2:0] REG_OFFSET   = 3'd1;
	localparam logic [2:0] REG_WAVE     = 3'd2;
	localparam logic [2:0] REG_SMOOTH   = 3'd3;
	localparam logic [2:0] REG_START    = 3'd4;
	localparam logic [2:0] REG_TARGET   = 3'd5;
	localparam logic [2:0] REG_FSTART   = 3'd6;
	localparam logic [2:0] REG_FDUR     = 3'd7;

	// wave codes
	localparam logic [1:0] WAVE_SINE   = 2'd0;
	localparam logic [1:0] WAVE_SQUARE = 2'd1;
	localparam logic [1:0] WAVE_HEART  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture time
		logic div_start; // start shared divider
		logic [2:0] div_sel; // which division to run
		logic fade_upd;  // write amplitude from fade quotient
		logic sine_step; // one sine evaluation step
		logic ecg_init;  // load first table value
		logic ecg_step;  // one smoothing round
		logic mul_lvl;   // form level product
		logic out_load;  // capture final level
	} pwg_cmd_t;

	typedef struct packed {
		logic div_done;
		logic fade_active;
		logic fade_hold;
		logic [4:0] smooth_n;
		logic [1:0] wave;
	} pwg_stat_t;

	localparam logic [2:0] DIV_PHASE = 3'd0;
	localparam logic [2:0] DIV_FADE  = 3'd1;
	localparam logic [2:0] DIV_IDX   = 3'd2;
	localparam logic [2:0] DIV_SMTH  = 3'd3;

	function automatic logic [7:0] ecg_rom(input logic [7:0] a);
		logic [7:0] v;
		case (a)
		8'd0: v=49; 8'd1: v=55; 8'd2: v=74; 8'd3: v=111; 8'd4: v=152; 8'd5: v=191;
		8'd6: v=222; 8'd7: v=244; 8'd8: v=255; 8'd9: v=255; 8'd10: v=240; 8'd11: v=195;
		8'd12: v=131; 8'd13: v=71; 8'd14: v=28; 8'd15: v=6; 8'd16: v=0; 8'd17: v=4;
		8'd18: v=12; 8'd19: v=18; 8'd20: v=24; 8'd21: v=28; 8'd22: v=32; 8'd23: v=34;
		8'd24: v=37; 8'd25: v=39; 8'd26: v=41; 8'd27: v=41; 8'd28: v=41; 8'd29: v=43;
		8'd30: v=43; 8'd31: v=43; 8'd32: v=43; 8'd33: v=43; 8'd34: v=43; 8'd35: v=45;
		8'd36: v=45; 8'd37: v=47; 8'd38: v=47; 8'd39: v=47; 8'd40: v=51; 8'd41: v=53;
		8'd42: v=53; 8'd43: v=51; 8'd44: v=51; 8'd45: v=53; 8'd46: v=55; 8'd47: v=57;
		8'd48: v=57; 8'd49: v=57; 8'd50: v=61; 8'd51: v=65; 8'd52: v=69; 8'd53: v=71;
		8'd54: v=74; 8'd55: v=74; 8'd56: v=74; 8'd57: v=78; 8'd58: v=78; 8'd59: v=80;
		8'd60: v=84; 8'd61: v=88; 8'd62: v=94; 8'd63: v=98; 8'd64: v=100; 8'd65: v=104;
		8'd66: v=108; 8'd67: v=115; 8'd68: v=119; 8'd69: v=123; 8'd70: v=125; 8'd71: v=127;
		8'd72: v=129; 8'd73: v=131; 8'd74: v=133; 8'd75: v=135; 8'd76: v=135; 8'd77: v=135;
		8'd78: v=133; 8'd79: v=131; 8'd80: v=129; 8'd81: v=127; 8'd82: v=121; 8'd83: v=115;
		8'd84: v=111; 8'd85: v=106; 8'd86: v=102; 8'd87: v=98; 8'd88: v=94; 8'd89: v=88;
		8'd90: v=82; 8'd91: v=78; 8'd92: v=76; 8'd93: v=74; 8'd94: v=69; 8'd95: v=65;
		8'd96: v=61; 8'd97: v=59; 8'd98: v=59; 8'd99: v=59; 8'd100: v=59; 8'd101: v=59;
		8'd102: v=59; 8'd103: v=57; 8'd104: v=53; 8'd105: v=51; 8'd106: v=51; 8'd107: v=51;
		8'd108: v=53; 8'd109: v=53; 8'd110: v=53; 8'd111: v=53; 8'd112: v=53; 8'd113: v=55;
		8'd114: v=57; 8'd115: v=57; 8'd116: v=59; 8'd117: v=59; 8'd118: v=59; 8'd119: v=59;
		8'd120: v=61; 8'd121: v=61; 8'd122: v=61; 8'd123: v=61; 8'd124: v=59; 8'd125: v=59;
		8'd126: v=59; 8'd127: v=59; 8'd128: v=61; 8'd129: v=63; 8'd130: v=65; 8'd131: v=61;
		8'd132: v=59; 8'd133: v=55; 8'd134: v=53; 8'd135: v=51; 8'd136: v=51; 8'd137: v=49;
		8'd138: v=47; 8'd139: v=47; 8'd140: v=47; 8'd141: v=47; 8'd142: v=47; 8'd143: v=45;
		8'd144: v=45; 8'd145: v=47; 8'd146: v=47; 8'd147: v=47; 8'd148: v=47; 8'd149: v=47;
		8'd150: v=49; 8'd151: v=49; 8'd152: v=47; 8'd153: v=47; 8'd154: v=47; 8'd155: v=47;
		8'd156: v=47; 8'd157: v=47; 8'd158: v=47; 8'd159: v=45; 8'd160: v=45; 8'd161: v=45;
		8'd162: v=45; 8'd163: v=45; 8'd164: v=45; 8'd165: v=43; 8'd166: v=43; 8'd167: v=43;
		8'd168: v=45; 8'd169: v=47; 8'd170: v=47; 8'd171: v=47; 8'd172: v=45; 8'd173: v=45;
		8'd174: v=45; 8'd175: v=45; 8'd176: v=45; 8'd177: v=47; 8'd178: v=47; 8'd179: v=47;
		8'd180: v=47; 8'd181: v=47; 8'd182: v=47; 8'd183: v=49; 8'd184: v=51; 8'd185: v=51;
		8'd186: v=49; 8'd187: v=47; 8'd188: v=47; 8'd189: v=47; 8'd190: v=47; 8'd191: v=49;
		8'd192: v=51; 8'd193: v=51; 8'd194: v=49; 8'd195: v=51; 8'd196: v=53; 8'd197: v=53;
		8'd198: v=53; 8'd199: v=51; 8'd200: v=51; 8'd201: v=51; 8'd202: v=51; 8'd203: v=53;
		8'd204: v=55; 8'd205: v=55; 8'd206: v=57; 8'd207: v=57; 8'd208: v=57; 8'd209: v=53;
		8'd210: v=49; 8'd211: v=47; 8'd212: v=49; 8'd213: v=49; 8'd214: v=49; 8'd215: v=49;
		8'd216: v=51; 8'd217: v=53; 8'd218: v=55; 8'd219: v=55; 8'd220: v=57; 8'd221: v=55;
		8'd222: v=53; 8'd223: v=53; 8'd224: v=55; 8'd225: v=55; 8'd226: v=57; 8'd227: v=59;
		8'd228: v=61; 8'd229: v=65; 8'd230: v=67; 8'd231: v=65; 8'd232: v=63; 8'd233: v=65;
		8'd234: v=69; 8'd235: v=71; 8'd236: v=71; 8'd237: v=67; 8'd238: v=65; 8'd239: v=61;
		8'd240: v=59; 8'd241: v=59; 8'd242: v=59; 8'd243: v=59; 8'd244: v=59; 8'd245: v=57;
		8'd246: v=57; 8'd247: v=57; 8'd248: v=59; 8'd249: v=57; 8'd250: v=55; 8'd251: v=51;
		8'd252: v=49;
		default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> design/pwg_div.sv
// ----------------------------------------------------------------------------
// pwg_div: shared restoring divider
// one quotient bit per cycle, 48-bit dividend, 16-bit divisor
// ----------------------------------------------------------------------------
`default_nettype none
module pwg_div
	import pwg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] dividend,
	input  wire logic [15:0] divisor,
	output logic [47:0]      quotient,
	output logic [15:0]      remainder,
	output logic             done
);
	logic [47:0] quo_q;
	logic [16:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], quo_q[47]};
	assign trial   = shifted - {1'b0, divisor};

	// one bit of quotient per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[15:0];
endmodule
`default_nettype wire

>>> design/pwg_ctrl.sv
// ----------------------------------------------------------------------------
// pwg_ctrl: sequencer of the waveform generator
// steps one item through fade, phase, wave evaluation and scaling
// ----------------------------------------------------------------------------
`default_nettype none
module pwg_ctrl
	import pwg_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_fire,
	input  wire logic  out_free,
	input  pwg_stat_t  stat,
	output pwg_cmd_t   cmd,
	output logic       busy
);
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FADE   = 4'd1;
	localparam logic [3:0] ST_FADEW  = 4'd2;
	localparam logic [3:0] ST_PHASE  = 4'd3;
	localparam logic [3:0] ST_PHASEW = 4'd4;
	localparam logic [3:0] ST_IDX    = 4'd5;
	localparam logic [3:0] ST_IDXW   = 4'd6;
	localparam logic [3:0] ST_SINE   = 4'd7;
	localparam logic [3:0] ST_ECG0   = 4'd8;
	localparam logic [3:0] ST_SMTH   = 4'd9;
	localparam logic [3:0] ST_SMTHW  = 4'd10;
	localparam logic [3:0] ST_MUL    = 4'd11;
	localparam logic [3:0] ST_OUT    = 4'd14;

	logic [3:0] state_q, state_d;
	logic [3:0] step_q;
	logic [4:0] rnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDX && stat.wave == WAVE_SINE) step_q <= '0;
			else if (state_q == ST_SINE) step_q <= step_q + 4'd1;
			if (state_q == ST_ECG0) rnd_q <= '0;
			else if (state_q == ST_SMTHW && stat.div_done) rnd_q <= rnd_q + 5'd1;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
		ST_IDLE: begin
			if (in_fire) begin
				cmd.load = 1'b1;
				state_d = ST_FADE;
			end
		end
		ST_FADE: begin
			if (stat.fade_active) begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_FADE;
				state_d = ST_FADEW;
			end else begin
				cmd.fade_upd = !stat.fade_hold;
				state_d = ST_PHASE;
			end
		end
		ST_FADEW: begin
			cmd.div_sel = DIV_FADE;
			if (stat.div_done) begin
				cmd.fade_upd = 1'b1;
				state_d = ST_PHASE;
			end
		end
		ST_PHASE: begin
			cmd.div_start = 1'b1;
			cmd.div_sel = DIV_PHASE;
			state_d = ST_PHASEW;
		end
		ST_PHASEW: begin
			cmd.div_sel = DIV_PHASE;
			if (stat.div_done) state_d = ST_IDX;
		end
		ST_IDX: begin
			if (stat.wave == WAVE_SINE || stat.wave == WAVE_HEART) begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_IDX;
				state_d = ST_IDXW;
			end else begin
				state_d = ST_MUL;
			end
		end
		ST_IDXW: begin
			cmd.div_sel = DIV_IDX;
			if (stat.div_done)
				state_d = (stat.wave == WAVE_SINE) ? ST_SINE : ST_ECG0;
		end
		ST_SINE: begin
			cmd.sine_step = 1'b1;
			if (step_q == 4'd12) state_d = ST_MUL;
		end
		ST_ECG0: begin
			cmd.ecg_init = 1'b1;
			state_d = ST_SMTH;
		end
		ST_SMTH: begin
			if (rnd_q == stat.smooth_n) begin
				state_d = ST_MUL;
			end else begin
				cmd.ecg_step = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_SMTH;
				state_d = ST_SMTHW;
			end
		end
		ST_SMTHW: begin
			cmd.div_sel = DIV_SMTH;
			if (stat.div_done) state_d = ST_SMTH;
		end
		ST_MUL: begin
			cmd.mul_lvl = 1'b1;
			state_d = ST_OUT;
		end
		ST_OUT: begin
			if (out_free) begin
				cmd.out_load = 1'b1;
				state_d = ST_IDLE;
			end
		end
		default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire

>>> design/pwg_dp.sv
// ----------------------------------------------------------------------------
// pwg_dp: datapath of the waveform generator
// holds configuration, amplitude state, sine series and ecg smoothing
// ----------------------------------------------------------------------------
`default_nettype none
module pwg_dp
	import pwg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic [TIME_BITS-1:0] time_ms,
	input  pwg_cmd_t                  cmd,
	output pwg_stat_t                 stat,
	output logic [LVL_W-1:0]          level
);
	localparam int SB = $clog2(SINE_STEPS);
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [31:0] HALF_PI = 32'd1686629713;
	// ceil(2^32 / 255), exact for products below 2^23
	localparam logic [24:0] RCP_255 = 25'd16843010;

	// configuration registers
	logic [PER_W-1:0] period_q;
	logic [31:0] offset_q, fstart_q;
	logic [1:0] wave_q;
	logic [4:0] smooth_q;
	logic [AMP_W-1:0] start_q, target_q, fdur_q;
	logic [15:0] amp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 15'd1000;
			offset_q <= '0;
			wave_q   <= WAVE_SINE;
			smooth_q <= '0;
			start_q  <= 15'd255;
			target_q <= 15'd255;
			fstart_q <= '0;
			fdur_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
			REG_PERIOD: period_q <= cfg_data[14:0];
			REG_OFFSET: offset_q <= cfg_data;
			REG_WAVE:   wave_q   <= cfg_data[1:0];
			REG_SMOOTH: smooth_q <= cfg_data[4:0];
			REG_START:  start_q  <= cfg_data[14:0];
			REG_TARGET: target_q <= cfg_data[14:0];
			REG_FSTART: fstart_q <= cfg_data;
			REG_FDUR:   fdur_q   <= cfg_data[14:0];
			default: ;
			endcase
		end
	end

	// captured time and derived values
	logic [TIME_BITS-1:0] time_q;
	logic [15:0] per;
	logic [TIME_BITS-1:0] fstart_t, ftime;
	logic before_start;
	logic [TIME_BITS:0] elapsed;
	logic up;
	logic [AMP_W-1:0] diff;

	assign per = (period_q == '0) ? 16'd1 : {1'b0, period_q};
	assign fstart_t = fstart_q[TIME_BITS-1:0];
	assign before_start = time_q < fstart_t;
	assign elapsed = {1'b0, time_q} - {1'b0, fstart_t};
	assign up = target_q >= start_q;
	assign diff = up ? target_q - start_q : start_q - target_q;
	assign stat.fade_active = !before_start && (elapsed < {{(TIME_BITS-14){1'b0}}, fdur_q});
	assign stat.fade_hold = !before_start;
	assign stat.wave = wave_q;
	assign stat.smooth_n = (smooth_q > 5'(MAX_SMOOTH)) ? 5'(MAX_SMOOTH) : smooth_q;
	assign ftime = time_q + offset_q[TIME_BITS-1:0];

	// divider operand selection
	logic [47:0] dvd;
	logic [15:0] dvs;
	logic [47:0] quo;
	logic [15:0] rem;
	logic div_done;
	logic [15:0] phase_q;
	logic [9:0] v_q;
	logic [4:0] rnd_q;
	logic [7:0] j_q;
	logic [31:0] prod_q;
	logic [7:0] up_i, dn_i;
	logic [5:0] odd_m;
	logic [5:0] rnd_i;

	assign rnd_i = {1'b0, rnd_q} + 6'd1;
	assign odd_m = {rnd_i[4:0], 1'b0} - 6'd1;

	always_comb begin
		dvd = '0;
		dvs = 16'd1;
		case (cmd.div_sel)
		DIV_PHASE: begin dvd = 48'(ftime); dvs = per; end
		DIV_FADE: begin dvd = 48'(32'(diff) * 32'(elapsed[14:0])); dvs = {1'b0, fdur_q}; end
		DIV_IDX: begin
			dvd = (wave_q == WAVE_SINE) ? 48'(32'(phase_q) * 32'(SINE_STEPS))
				: 48'(32'(phase_q) * 32'(ECG_LEN));
			dvs = per;
		end
		DIV_SMTH: begin
			dvd = 48'(16'(odd_m) * 16'(v_q) + 16'(ecg_rom(up_i)) + 16'(ecg_rom(dn_i)));
			dvs = 16'({rnd_i, 1'b1});
		end
		default: ;
		endcase
	end

	pwg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd), .divisor(dvs), .quotient(quo), .remainder(rem), .done(div_done)
	);
	assign stat.div_done = div_done;

	// ecg neighbor indexes, wrapping both ways
	logic [8:0] up_s, dn_s;
	assign up_s = {1'b0, j_q} + 9'(rnd_i);
	assign dn_s = {1'b0, j_q} + 9'(ECG_LEN) - 9'(rnd_i);
	assign up_i = (up_s >= 9'(ECG_LEN)) ? 8'(up_s - 9'(ECG_LEN)) : up_s[7:0];
	assign dn_i = (dn_s >= 9'(ECG_LEN)) ? 8'(dn_s - 9'(ECG_LEN)) : dn_s[7:0];

	// sine series state
	logic [SB-1:0] k_q;
	logic [1:0] quad;
	logic [29:0] rfrac;
	logic [30:0] rr;
	logic [31:0] t_q, t2_q, acc_q, pm_q;
	logic [3:0] sst_q;
	logic sneg_q;
	logic [15:0] smag_q;
	logic [63:0] mul_a;
	logic [31:0] mulr;
	logic [2:0] term_q;
	logic [35:0] rcp;
	logic [67:0] qt;
	logic [31:0] s_val;
	logic [17:0] magr;
	logic [47:0] lvl_prod;

	// k/SINE_STEPS in Q32: quadrant and fraction bits
	logic [31+SB:0] f_full;
	assign f_full = {k_q, 32'd0} >> SB;
	assign quad = f_full[31:30];
	assign rfrac = f_full[29:0];
	assign rr = quad[0] ? 31'(Q30_ONE) - {1'b0, rfrac} : {1'b0, rfrac};

	// reciprocals ceil(2^38 / d) of the series divisors 110, 72, 42, 20, 6
	always_comb begin
		case (term_q)
		3'd0: rcp = 36'd2498890064;
		3'd1: rcp = 36'd3817748708;
		3'd2: rcp = 36'd6544712071;
		3'd3: rcp = 36'd13743895348;
		default: rcp = 36'd45812984491;
		endcase
	end

	// term quotient by reciprocal multiply, exact for the series range
	assign qt = 68'(pm_q) * 68'(rcp);

	// one multiply per sine step
	always_comb begin
		mul_a = '0;
		case (sst_q)
		4'd0: mul_a = 64'(rr) * 64'(HALF_PI);
		4'd1: mul_a = 64'(t_q) * 64'(t_q);
		4'd12: mul_a = 64'(t_q) * 64'(acc_q);
		default: mul_a = 64'(t2_q) * 64'(acc_q);
		endcase
	end
	assign mulr = 32'(mul_a >> 30);
	assign s_val = mulr;
	assign magr = 18'((s_val + 32'd16384) >> 15);

	// heartbeat scaling by 1/255
	assign lvl_prod = 48'(prod_q[22:0]) * 48'(RCP_255);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= 16'd255;
		end else if (cmd.fade_upd) begin
			if (cmd.div_sel == DIV_FADE)
				amp_q <= up ? 16'(start_q) + quo[15:0] : 16'(start_q) - quo[15:0];
			else
				amp_q <= 16'(start_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) time_q <= time_ms;
		if (div_done && cmd.div_sel == DIV_PHASE) phase_q <= rem;
		if (div_done && cmd.div_sel == DIV_IDX) begin
			k_q <= quo[SB-1:0];
			j_q <= (quo[7:0] >= 8'(ECG_LEN)) ? 8'd0 : quo[7:0];
			sst_q <= '0;
			term_q <= '0;
			acc_q <= 32'(Q30_ONE);
		end
		if (cmd.sine_step) begin
			sst_q <= sst_q + 4'd1;
			case (sst_q)
			4'd0: begin t_q <= mulr; sneg_q <= quad[1]; end
			4'd1: t2_q <= mulr;
			4'd2, 4'd4, 4'd6, 4'd8, 4'd10: pm_q <= mulr;
			4'd3, 4'd5, 4'd7, 4'd9, 4'd11: begin
				acc_q <= 32'(Q30_ONE) - 32'(qt[67:38]);
				term_q <= term_q + 3'd1;
			end
			4'd12: smag_q <= (magr > 18'd32767) ? 16'd32767 : 16'(magr);
			default: ;
			endcase
		end
		if (cmd.ecg_init) begin
			v_q <= {2'b0, ecg_rom(j_q)};
			rnd_q <= '0;
		end
		if (div_done && cmd.div_sel == DIV_SMTH) begin
			v_q <= quo[9:0];
			rnd_q <= rnd_q + 5'd1;
		end
		if (cmd.mul_lvl) begin
			case (wave_q)
			WAVE_SINE: prod_q <= 32'((32'({1'b0, sneg_q ? 16'd32768 - smag_q : 16'd32768 + smag_q})
				* 32'(amp_q)) >> 16);
			WAVE_SQUARE: prod_q <= ({15'd0, phase_q, 1'b0} > 32'(per)) ? 32'(amp_q) : 32'd0;
			WAVE_HEART: prod_q <= 32'(v_q) * 32'(amp_q);
			default: prod_q <= '0;
			endcase
		end
		if (cmd.out_load)
			level <= (wave_q == WAVE_HEART) ? lvl_prod[46:32] : prod_q[LVL_W-1:0];
	end
	logic unused_ok;
	assign unused_ok = ^{dvd[47:47], mul_a[63:62], qt[37:0], prod_q[31:23],
		lvl_prod[47], lvl_prod[31:0]};
endmodule
`default_nettype wire

>>> design/periodic_waveform_generator.sv
// ----------------------------------------------------------------------------
// periodic_waveform_generator: sine, square and heartbeat wave with fade
// sequenced controller with one shared bit-serial divider
// ----------------------------------------------------------------------------
// usage:
//  s_axis carries one time stamp per item; m_axis returns one level per item
//  config writes through cfg_we/cfg_index/cfg_data, only while idle
//  each item takes one pass through a controller; it runs a division on the
//  shared 48-step divider for fade (inside the fade window only), phase,
//  table index (sine and heartbeat) and each smoothing round
//  the next item can be accepted in the cycle after the level is loaded
//  one item is in work at a time; s_axis_tready is high only when idle
//  the result sits in an output register; a stalled receiver holds the
//  level, the block finishes the next item behind it and then waits,
//  which keeps s_axis_tready low until the receiver takes the level
//  reset restores config, control and valid registers, amplitude 255
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_waveform_generator
	import pwg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // time_ms[31:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // level[14:0], zero pad
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	pwg_cmd_t cmd;
	pwg_stat_t stat;
	logic busy, in_fire, out_free;
	logic [LVL_W-1:0] level;
	logic valid_q;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !valid_q || m_axis_tready;

	pwg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	pwg_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .time_ms(s_axis_tdata[TIME_BITS-1:0]), .cmd(cmd),
		.stat(stat), .level(level)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cmd.out_load) valid_q <= 1'b1;
		else if (m_axis_tready) valid_q <= 1'b0;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {1'b0, level};
endmodule
`default_nettype wire

>>> tb/pwg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwg_checker: level predictor and scoreboard for the waveform generator
// mirrors the register writes, predicts each level from accepted time stamps
// and compares the accepted levels in order
// ----------------------------------------------------------------------------
module pwg_checker
	import pwg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	localparam int STEPS   = 1024;
	localparam int SMTH_MX = 16;
	localparam longint unsigned Q30 = 64'd1073741824;
	localparam longint unsigned HPI = 64'd1686629713;

	// mirrored register file and amplitude state
	logic [14:0] period, amp_start, amp_target, fade_len;
	logic [31:0] offset, fade_t0;
	logic [1:0]  wave;
	logic [4:0]  smooth;
	logic [15:0] amp_now;
	logic [14:0] level_q[$];

	function automatic int signed sine_val(input longint unsigned k);
		longint unsigned f, r, t, t2, acc, s, mag;
		int unsigned quad;
		int unsigned dv[5];
		dv = '{110, 72, 42, 20, 6};
		f = (k << 32) / STEPS;
		quad = (f >> 30) & 3;
		r = f & (Q30 - 1);
		if (quad[0])
			r = Q30 - r;
		t = (r * HPI) >> 30;
		t2 = (t * t) >> 30;
		acc = Q30;
		for (int i = 0; i < 5; i++)
			acc = Q30 - ((t2 * acc) >> 30) / dv[i];
		s = (t * acc) >> 30;
		mag = (s + 16384) >> 15;
		if (mag > 32767)
			mag = 32767;
		return quad[1] ? -int'(mag) : int'(mag);
	endfunction

	// updates amp_now from the time stamp, then forms the level
	function automatic logic [14:0] predict_level(input logic [31:0] ts);
		longint unsigned per, ph, e, q, lv, amp;
		int unsigned j, n, v, up, dn;
		int signed sv;
		per = (period == 0) ? 1 : period;
		ph = ((64'(ts) + offset) & 64'hFFFF_FFFF) % per;
		if (ts < fade_t0) begin
			amp_now = amp_start;
		end else begin
			e = 64'(ts) - fade_t0;
			if (e < fade_len) begin
				if (amp_target >= amp_start) begin
					q = 64'(amp_target - amp_start) * e / fade_len;
					amp_now = 16'(amp_start + q);
				end else begin
					q = 64'(amp_start - amp_target) * e / fade_len;
					amp_now = 16'(amp_start - q);
				end
			end
		end
		amp = amp_now;
		lv = 0;
		case (wave)
		WAVE_SINE: begin
			sv = sine_val(ph * STEPS / per);
			lv = (64'(sv + 32768) * amp) >> 16;
		end
		WAVE_SQUARE: lv = (ph * 2 > per) ? amp : 0;
		WAVE_HEART: begin
			j = (ph * ECG_LEN / per) % ECG_LEN;
			n = (smooth > SMTH_MX) ? SMTH_MX : smooth;
			v = ecg_rom(8'(j));
			for (int unsigned i = 1; i <= n; i++) begin
				up = (j + i) % ECG_LEN;
				dn = (j + ECG_LEN - i) % ECG_LEN;
				v = ((2 * i - 1) * v + ecg_rom(8'(up)) + ecg_rom(8'(dn))) / (2 * i + 1);
			end
			lv = 64'(v) * amp / 255;
		end
		default: lv = 0;
		endcase
		return lv[14:0];
	endfunction

	assign pending = level_q.size();

	// watch config, input and output channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period     <= 15'd1000;
			offset     <= '0;
			wave       <= WAVE_SINE;
			smooth     <= '0;
			amp_start  <= 15'd255;
			amp_target <= 15'd255;
			fade_t0    <= '0;
			fade_len   <= '0;
			amp_now    <= 16'd255;
			fail_count <= 0;
			level_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_PERIOD: period     <= cfg_data[14:0];
				REG_OFFSET: offset     <= cfg_data;
				REG_WAVE:   wave       <= cfg_data[1:0];
				REG_SMOOTH: smooth     <= cfg_data[4:0];
				REG_START:  amp_start  <= cfg_data[14:0];
				REG_TARGET: amp_target <= cfg_data[14:0];
				REG_FSTART: fade_t0    <= cfg_data;
				REG_FDUR:   fade_len   <= cfg_data[14:0];
				default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				level_q.push_back(predict_level(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (level_q.size() == 0) begin
					$error("level: unexpected item 0x%0h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					logic [14:0] exp_lvl;
					exp_lvl = level_q.pop_front();
					if (m_axis_tdata != {1'b0, exp_lvl}) begin
						$error("level: expected %0d, actual %0d", exp_lvl, m_axis_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus for the periodic waveform generator
// walks through register settings, sends directed and random time stamps
// with random gaps and stalls, and reports the checker verdict
// ----------------------------------------------------------------------------
module tb_top;
	import pwg_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count, pending;
	bit          calm = 1'b0;
	bit          hold_long = 1'b0;

	periodic_waveform_generator DUT (.*);

	pwg_checker u_check (.*);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random stall bursts, one long hold-off
	initial begin
		int n;
		@(negedge clk);
		forever begin
			if (hold_long) begin
				m_axis_tready <= 1'b0;
				for (n = 0; n < 1500; n++)
					@(negedge clk);
				hold_long = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	// one write, then cfg_we low again before the task returns
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering, wait for all levels, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// offer one time stamp; valid stays up for a following item
	task automatic send_time(input logic [31:0] ts);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ts;
		while (!s_axis_tready)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic random_setup(input bit extreme);
		reg_write(REG_PERIOD, extreme ? ($urandom_range(0, 1) ? 32'd32767 : 32'd0)
			: $urandom_range(0, 1) ? $urandom_range(1, 2000) : $urandom_range(0, 32767));
		reg_write(REG_OFFSET, extreme ? 32'hFFFF_FFFF : $urandom());
		reg_write(REG_WAVE, $urandom_range(0, 3));
		reg_write(REG_SMOOTH, extreme ? 32'd31 : $urandom_range(0, 31));
		reg_write(REG_START, extreme ? 32'd32767 : $urandom_range(0, 32767));
		reg_write(REG_TARGET, extreme ? 32'd0 : $urandom_range(0, 32767));
		reg_write(REG_FSTART, $urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom());
		reg_write(REG_FDUR, extreme ? 32'd32767 : $urandom_range(0, 32767));
	endtask

	initial begin
		logic [31:0] base;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: sine, amplitude 255
		send_time(32'd0);
		send_time(32'd250);
		send_time(32'd750);
		send_time(32'hFFFF_FFFF);

		// each wave code with full amplitude and max smoothing
		for (int w = 0; w < 4; w++) begin
			drain();
			reg_write(REG_WAVE, w);
			reg_write(REG_SMOOTH, 32'd31);
			reg_write(REG_START, 32'd32767);
			reg_write(REG_FSTART, 32'hFFFF_FFFF);
			send_time(32'd0);
			send_time(32'd499);
			send_time(32'd501);
			send_time(32'hFFFF_FFFE);
		end

		// fade up, with times before, inside and after the fade window
		drain();
		reg_write(REG_WAVE, WAVE_SQUARE);
		reg_write(REG_PERIOD, 32'd2);
		reg_write(REG_START, 32'd0);
		reg_write(REG_TARGET, 32'd32767);
		reg_write(REG_FSTART, 32'd100);
		reg_write(REG_FDUR, 32'd32767);
		send_time(32'd99);
		send_time(32'd101);
		send_time(32'd16483);
		send_time(32'd40000);
		send_time(32'd41);

		// random phases, hold-off during the second
		for (int p = 0; p < 22; p++) begin
			drain();
			random_setup(p < 3);
			if (p == 1)
				hold_long = 1'b1;
			if (p == 20)
				calm = 1'b1;
			base = $urandom();
			for (int i = 0; i < 75; i++) begin
				case ($urandom_range(0, 3))
				0: send_time($urandom());
				1: send_time(u_check.fade_t0 + $urandom_range(0, 40000));
				default: send_time(base + i * $urandom_range(1, 300));
				endcase
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#(64'd200_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
